@@ rtl/rvd_pkg.sv @@
// Shared types and constants for the RV32IM instruction decoder.
package rvd_pkg;

    localparam int unsigned TABLE_LEN = 48;

    // Encoding formats as reported on the result port
    typedef enum logic [2:0] {
        FMT_R    = 3'd0,
        FMT_I    = 3'd1,
        FMT_S    = 3'd2,
        FMT_B    = 3'd3,
        FMT_U    = 3'd4,
        FMT_J    = 3'd5,
        FMT_NONE = 3'd6
    } t_fmt;

    // Instruction table positions, in table order
    typedef enum logic [5:0] {
        IDX_LUI, IDX_AUIPC, IDX_JAL, IDX_JALR,
        IDX_BEQ, IDX_BNE, IDX_BLT, IDX_BGE, IDX_BLTU, IDX_BGEU,
        IDX_LB, IDX_LH, IDX_LW, IDX_LBU, IDX_LHU,
        IDX_SB, IDX_SH, IDX_SW,
        IDX_ADDI, IDX_SLTI, IDX_SLTIU, IDX_XORI, IDX_ORI, IDX_ANDI,
        IDX_SLLI, IDX_SRLI, IDX_SRAI,
        IDX_ADD, IDX_SUB, IDX_SLL, IDX_SLT, IDX_SLTU, IDX_XOR,
        IDX_SRL, IDX_SRA, IDX_OR, IDX_AND,
        IDX_FENCE, IDX_ECALL, IDX_EBREAK,
        IDX_MUL, IDX_MULH, IDX_MULHSU, IDX_MULHU,
        IDX_DIV, IDX_DIVU, IDX_REM, IDX_REMU
    } t_instr_idx;

    // Major opcodes
    localparam logic [6:0] OPC_LUI      = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC    = 7'b0010111;
    localparam logic [6:0] OPC_JAL      = 7'b1101111;
    localparam logic [6:0] OPC_JALR     = 7'b1100111;
    localparam logic [6:0] OPC_BRANCH   = 7'b1100011;
    localparam logic [6:0] OPC_LOAD     = 7'b0000011;
    localparam logic [6:0] OPC_STORE    = 7'b0100011;
    localparam logic [6:0] OPC_OPIMM    = 7'b0010011;
    localparam logic [6:0] OPC_OP       = 7'b0110011;
    localparam logic [6:0] OPC_MISC_MEM = 7'b0001111;
    localparam logic [6:0] OPC_SYSTEM   = 7'b1110011;

    // funct3 codes
    localparam logic [2:0] F3_JALR  = 3'd0;
    localparam logic [2:0] F3_FENCE = 3'd0;
    localparam logic [2:0] F3_BEQ   = 3'd0;
    localparam logic [2:0] F3_BNE   = 3'd1;
    localparam logic [2:0] F3_BLT   = 3'd4;
    localparam logic [2:0] F3_BGE   = 3'd5;
    localparam logic [2:0] F3_BLTU  = 3'd6;
    localparam logic [2:0] F3_BGEU  = 3'd7;
    localparam logic [2:0] F3_LB    = 3'd0;
    localparam logic [2:0] F3_LH    = 3'd1;
    localparam logic [2:0] F3_LW    = 3'd2;
    localparam logic [2:0] F3_LBU   = 3'd4;
    localparam logic [2:0] F3_LHU   = 3'd5;
    localparam logic [2:0] F3_SB    = 3'd0;
    localparam logic [2:0] F3_SH    = 3'd1;
    localparam logic [2:0] F3_SW    = 3'd2;
    localparam logic [2:0] F3_ADD   = 3'd0;
    localparam logic [2:0] F3_SLL   = 3'd1;
    localparam logic [2:0] F3_SLT   = 3'd2;
    localparam logic [2:0] F3_SLTU  = 3'd3;
    localparam logic [2:0] F3_XOR   = 3'd4;
    localparam logic [2:0] F3_SR    = 3'd5;
    localparam logic [2:0] F3_OR    = 3'd6;
    localparam logic [2:0] F3_AND   = 3'd7;
    localparam logic [2:0] F3_MUL    = 3'd0;
    localparam logic [2:0] F3_MULH   = 3'd1;
    localparam logic [2:0] F3_MULHSU = 3'd2;
    localparam logic [2:0] F3_MULHU  = 3'd3;
    localparam logic [2:0] F3_DIV    = 3'd4;
    localparam logic [2:0] F3_DIVU   = 3'd5;
    localparam logic [2:0] F3_REM    = 3'd6;
    localparam logic [2:0] F3_REMU   = 3'd7;

    // funct7 codes
    localparam logic [6:0] F7_BASE   = 7'b0000000;
    localparam logic [6:0] F7_ALT    = 7'b0100000;
    localparam logic [6:0] F7_MULDIV = 7'b0000001;

    // SYSTEM imm[11:0] codes
    localparam logic [11:0] SYS_ECALL  = 12'h000;
    localparam logic [11:0] SYS_EBREAK = 12'h001;

    // Sign-fill masks for the immediate formats
    localparam logic [31:0] SEXT_12 = 32'hFFFFF800;
    localparam logic [31:0] SEXT_13 = 32'hFFFFF000;
    localparam logic [31:0] SEXT_21 = 32'hFFF00000;
    localparam logic [31:0] UPPER_MASK = 32'hFFFFF000;

    typedef struct packed {
        logic       valid;
        t_instr_idx idx;
        t_fmt       fmt;
    } t_match;

    function automatic t_match match_of(input t_instr_idx idx, input t_fmt fmt);
        t_match m;
        m.valid = 1'b1;
        m.idx   = idx;
        m.fmt   = fmt;
        return m;
    endfunction

endpackage

@@ rtl/rvd_match.sv @@
// Table match: instruction index and format from opcode, funct3, funct7 and imm[11:0].
module rvd_match (
    input  logic [31:0]          i_word,
    output rvd_pkg::t_match      o_match
);

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [11:0] imm12;

    assign opc   = i_word[6:0];
    assign f3    = i_word[14:12];
    assign f7    = i_word[31:25];
    assign imm12 = i_word[31:20];

    always_comb begin
        o_match.valid = 1'b0;
        o_match.idx   = rvd_pkg::IDX_LUI;
        o_match.fmt   = rvd_pkg::FMT_NONE;
        case (opc)
            rvd_pkg::OPC_LUI: begin
                o_match = rvd_pkg::match_of(rvd_pkg::IDX_LUI, rvd_pkg::FMT_U);
            end
            rvd_pkg::OPC_AUIPC: begin
                o_match = rvd_pkg::match_of(rvd_pkg::IDX_AUIPC, rvd_pkg::FMT_U);
            end
            rvd_pkg::OPC_JAL: begin
                o_match = rvd_pkg::match_of(rvd_pkg::IDX_JAL, rvd_pkg::FMT_J);
            end
            rvd_pkg::OPC_JALR: begin
                if (f3 == rvd_pkg::F3_JALR)
                    o_match = rvd_pkg::match_of(rvd_pkg::IDX_JALR, rvd_pkg::FMT_I);
            end
            rvd_pkg::OPC_BRANCH: begin
                case (f3)
                    rvd_pkg::F3_BEQ:  o_match = rvd_pkg::match_of(rvd_pkg::IDX_BEQ, rvd_pkg::FMT_B);
                    rvd_pkg::F3_BNE:  o_match = rvd_pkg::match_of(rvd_pkg::IDX_BNE, rvd_pkg::FMT_B);
                    rvd_pkg::F3_BLT:  o_match = rvd_pkg::match_of(rvd_pkg::IDX_BLT, rvd_pkg::FMT_B);
                    rvd_pkg::F3_BGE:  o_match = rvd_pkg::match_of(rvd_pkg::IDX_BGE, rvd_pkg::FMT_B);
                    rvd_pkg::F3_BLTU: o_match = rvd_pkg::match_of(rvd_pkg::IDX_BLTU, rvd_pkg::FMT_B);
                    rvd_pkg::F3_BGEU: o_match = rvd_pkg::match_of(rvd_pkg::IDX_BGEU, rvd_pkg::FMT_B);
                    default: ;
                endcase
            end
            rvd_pkg::OPC_LOAD: begin
                case (f3)
                    rvd_pkg::F3_LB:  o_match = rvd_pkg::match_of(rvd_pkg::IDX_LB, rvd_pkg::FMT_I);
                    rvd_pkg::F3_LH:  o_match = rvd_pkg::match_of(rvd_pkg::IDX_LH, rvd_pkg::FMT_I);
                    rvd_pkg::F3_LW:  o_match = rvd_pkg::match_of(rvd_pkg::IDX_LW, rvd_pkg::FMT_I);
                    rvd_pkg::F3_LBU: o_match = rvd_pkg::match_of(rvd_pkg::IDX_LBU, rvd_pkg::FMT_I);
                    rvd_pkg::F3_LHU: o_match = rvd_pkg::match_of(rvd_pkg::IDX_LHU, rvd_pkg::FMT_I);
                    default: ;
                endcase
            end
            rvd_pkg::OPC_STORE: begin
                case (f3)
                    rvd_pkg::F3_SB: o_match = rvd_pkg::match_of(rvd_pkg::IDX_SB, rvd_pkg::FMT_S);
                    rvd_pkg::F3_SH: o_match = rvd_pkg::match_of(rvd_pkg::IDX_SH, rvd_pkg::FMT_S);
                    rvd_pkg::F3_SW: o_match = rvd_pkg::match_of(rvd_pkg::IDX_SW, rvd_pkg::FMT_S);
                    default: ;
                endcase
            end
            rvd_pkg::OPC_OPIMM: begin
                case (f3)
                    rvd_pkg::F3_ADD:  o_match = rvd_pkg::match_of(rvd_pkg::IDX_ADDI, rvd_pkg::FMT_I);
                    rvd_pkg::F3_SLT:  o_match = rvd_pkg::match_of(rvd_pkg::IDX_SLTI, rvd_pkg::FMT_I);
                    rvd_pkg::F3_SLTU: o_match = rvd_pkg::match_of(rvd_pkg::IDX_SLTIU, rvd_pkg::FMT_I);
                    rvd_pkg::F3_XOR:  o_match = rvd_pkg::match_of(rvd_pkg::IDX_XORI, rvd_pkg::FMT_I);
                    rvd_pkg::F3_OR:   o_match = rvd_pkg::match_of(rvd_pkg::IDX_ORI, rvd_pkg::FMT_I);
                    rvd_pkg::F3_AND:  o_match = rvd_pkg::match_of(rvd_pkg::IDX_ANDI, rvd_pkg::FMT_I);
                    rvd_pkg::F3_SLL:  o_match = rvd_pkg::match_of(rvd_pkg::IDX_SLLI, rvd_pkg::FMT_I);
                    rvd_pkg::F3_SR: begin
                        // right shifts also need funct7; slli does not
                        if (f7 == rvd_pkg::F7_BASE)
                            o_match = rvd_pkg::match_of(rvd_pkg::IDX_SRLI, rvd_pkg::FMT_I);
                        else if (f7 == rvd_pkg::F7_ALT)
                            o_match = rvd_pkg::match_of(rvd_pkg::IDX_SRAI, rvd_pkg::FMT_I);
                    end
                    default: ;
                endcase
            end
            rvd_pkg::OPC_OP: begin
                if (f7 == rvd_pkg::F7_BASE) begin
                    case (f3)
                        rvd_pkg::F3_ADD:  o_match = rvd_pkg::match_of(rvd_pkg::IDX_ADD, rvd_pkg::FMT_R);
                        rvd_pkg::F3_SLL:  o_match = rvd_pkg::match_of(rvd_pkg::IDX_SLL, rvd_pkg::FMT_R);
                        rvd_pkg::F3_SLT:  o_match = rvd_pkg::match_of(rvd_pkg::IDX_SLT, rvd_pkg::FMT_R);
                        rvd_pkg::F3_SLTU: o_match = rvd_pkg::match_of(rvd_pkg::IDX_SLTU, rvd_pkg::FMT_R);
                        rvd_pkg::F3_XOR:  o_match = rvd_pkg::match_of(rvd_pkg::IDX_XOR, rvd_pkg::FMT_R);
                        rvd_pkg::F3_SR:   o_match = rvd_pkg::match_of(rvd_pkg::IDX_SRL, rvd_pkg::FMT_R);
                        rvd_pkg::F3_OR:   o_match = rvd_pkg::match_of(rvd_pkg::IDX_OR, rvd_pkg::FMT_R);
                        rvd_pkg::F3_AND:  o_match = rvd_pkg::match_of(rvd_pkg::IDX_AND, rvd_pkg::FMT_R);
                        default: ;
                    endcase
                end else if (f7 == rvd_pkg::F7_ALT) begin
                    case (f3)
                        rvd_pkg::F3_ADD: o_match = rvd_pkg::match_of(rvd_pkg::IDX_SUB, rvd_pkg::FMT_R);
                        rvd_pkg::F3_SR:  o_match = rvd_pkg::match_of(rvd_pkg::IDX_SRA, rvd_pkg::FMT_R);
                        default: ;
                    endcase
                end else if (f7 == rvd_pkg::F7_MULDIV) begin
                    case (f3)
                        rvd_pkg::F3_MUL:    o_match = rvd_pkg::match_of(rvd_pkg::IDX_MUL, rvd_pkg::FMT_R);
                        rvd_pkg::F3_MULH:   o_match = rvd_pkg::match_of(rvd_pkg::IDX_MULH, rvd_pkg::FMT_R);
                        rvd_pkg::F3_MULHSU: o_match = rvd_pkg::match_of(rvd_pkg::IDX_MULHSU, rvd_pkg::FMT_R);
                        rvd_pkg::F3_MULHU:  o_match = rvd_pkg::match_of(rvd_pkg::IDX_MULHU, rvd_pkg::FMT_R);
                        rvd_pkg::F3_DIV:    o_match = rvd_pkg::match_of(rvd_pkg::IDX_DIV, rvd_pkg::FMT_R);
                        rvd_pkg::F3_DIVU:   o_match = rvd_pkg::match_of(rvd_pkg::IDX_DIVU, rvd_pkg::FMT_R);
                        rvd_pkg::F3_REM:    o_match = rvd_pkg::match_of(rvd_pkg::IDX_REM, rvd_pkg::FMT_R);
                        rvd_pkg::F3_REMU:   o_match = rvd_pkg::match_of(rvd_pkg::IDX_REMU, rvd_pkg::FMT_R);
                        default: ;
                    endcase
                end
            end
            rvd_pkg::OPC_MISC_MEM: begin
                if (f3 == rvd_pkg::F3_FENCE)
                    o_match = rvd_pkg::match_of(rvd_pkg::IDX_FENCE, rvd_pkg::FMT_I);
            end
            rvd_pkg::OPC_SYSTEM: begin
                // funct3, rd and rs1 are ignored here
                if (imm12 == rvd_pkg::SYS_ECALL)
                    o_match = rvd_pkg::match_of(rvd_pkg::IDX_ECALL, rvd_pkg::FMT_I);
                else if (imm12 == rvd_pkg::SYS_EBREAK)
                    o_match = rvd_pkg::match_of(rvd_pkg::IDX_EBREAK, rvd_pkg::FMT_I);
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/rvd_imm.sv @@
// Immediate assembly and sign extension for the I, S, B, U and J formats.
module rvd_imm (
    input  logic [31:0]   i_word,
    input  rvd_pkg::t_fmt i_fmt,
    output logic [31:0]   o_imm
);

    logic neg;

    assign neg = i_word[31];

    always_comb begin
        case (i_fmt)
            rvd_pkg::FMT_I: begin
                o_imm = (neg ? rvd_pkg::SEXT_12 : 32'd0) | {21'd0, i_word[30:20]};
            end
            rvd_pkg::FMT_S: begin
                o_imm = (neg ? rvd_pkg::SEXT_12 : 32'd0)
                      | {21'd0, i_word[30:25], i_word[11:7]};
            end
            rvd_pkg::FMT_B: begin
                o_imm = (neg ? rvd_pkg::SEXT_13 : 32'd0)
                      | {20'd0, i_word[7], i_word[30:25], i_word[11:8], 1'b0};
            end
            rvd_pkg::FMT_U: begin
                o_imm = i_word & rvd_pkg::UPPER_MASK;
            end
            rvd_pkg::FMT_J: begin
                o_imm = (neg ? rvd_pkg::SEXT_21 : 32'd0)
                      | {12'd0, i_word[19:12], i_word[20], i_word[30:21], 1'b0};
            end
            default: begin
                // R format and unknown words carry no immediate
                o_imm = 32'd0;
            end
        endcase
    end

endmodule

@@ rtl/rv32im_instruction_decoder.sv @@
// Top level of the RV32IM instruction decoder: input register, decode, result register.
//
// Decodes one 32-bit RV32IM instruction word per request. A request is taken on
// any clock edge where start is high; busy is never raised, so a new word may be
// issued every cycle. The word is captured in the input register, then passes through
// the table match and immediate logic into the result register, and the result is
// marked by o_strobe for exactly one cycle; results come
// out in request order and cannot be stalled. A word that matches no table entry
// gives o_valid_res 0, o_instr_index 0, o_format_code 6 and o_immediate 0, while
// the raw register, opcode and funct fields are still reported.
module rv32im_instruction_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        i_instr_word,
    output logic               o_strobe,
    output logic               o_valid_res,
    output logic [5:0]         o_instr_index,
    output logic [2:0]         o_format_code,
    output logic [4:0]         o_rd,
    output logic [4:0]         o_rs1,
    output logic [4:0]         o_rs2,
    output logic [6:0]         o_major_opcode,
    output logic [2:0]         o_func3,
    output logic [6:0]         o_func7,
    output logic signed [31:0] o_immediate
);

    logic            r_word_vld;
    logic [31:0]     r_word;
    rvd_pkg::t_match dec_match;
    logic [31:0]     dec_imm;

    logic            r_strobe;
    logic            r_valid_res;
    logic [5:0]      r_instr_index;
    logic [2:0]      r_format_code;
    logic [31:0]     r_res_word;
    logic [31:0]     r_immediate;

    assign busy = 1'b0;

    rvd_match u_match (
        .i_word  (r_word),
        .o_match (dec_match)
    );

    rvd_imm u_imm (
        .i_word (r_word),
        .i_fmt  (dec_match.fmt),
        .o_imm  (dec_imm)
    );

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_vld <= 1'b0;
        end else begin
            r_word_vld <= start && !busy;
        end
        if (start && !busy)
            r_word <= i_instr_word;
    end

    // Result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_word_vld;
        end
        if (r_word_vld) begin
            r_valid_res   <= dec_match.valid;
            r_instr_index <= dec_match.idx;
            r_format_code <= dec_match.fmt;
            r_res_word    <= r_word;
            r_immediate   <= dec_imm;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_valid_res    = r_valid_res;
    assign o_instr_index  = r_instr_index;
    assign o_format_code  = r_format_code;
    assign o_rd           = r_res_word[11:7];
    assign o_rs1          = r_res_word[19:15];
    assign o_rs2          = r_res_word[24:20];
    assign o_major_opcode = r_res_word[6:0];
    assign o_func3        = r_res_word[14:12];
    assign o_func7        = r_res_word[31:25];
    assign o_immediate    = $signed(r_immediate);

    // A result strobe follows its request through the input and result registers
    a_strobe_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, 2))
        else $error("result strobe without a request two cycles earlier");

    // Unknown words report format none, index zero and no immediate
    a_invalid_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_valid_res) |->
            (o_format_code == rvd_pkg::FMT_NONE && o_instr_index == 6'd0
             && o_immediate == 32'sd0))
        else $error("invalid result with non-default fields");

    // A matched word never reports format none and stays inside the table
    a_valid_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_valid_res) |->
            (o_format_code != rvd_pkg::FMT_NONE
             && o_instr_index < 6'(rvd_pkg::TABLE_LEN)))
        else $error("valid result with bad format or index");

    // R-type carries no immediate
    a_rtype_imm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_format_code == rvd_pkg::FMT_R) |-> (o_immediate == 32'sd0))
        else $error("R-type result with nonzero immediate");

    // U-type immediate has its low twelve bits clear
    a_utype_imm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_format_code == rvd_pkg::FMT_U) |-> (o_immediate[11:0] == 12'd0))
        else $error("U-type immediate with low bits set");

endmodule
